// ----- hdl/miller_rabin_primality_test_top_macros.svh -----
// assertion macros for the primality test block
// used by the top level only
`ifndef MILLER_RABIN_PRIMALITY_TEST_TOP_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_TOP_MACROS_SVH

// check a property on aclk, off during reset
`define MRPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check a property on aclk at every edge
`define MRPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/mrpt_pkg.sv -----
// package for the primality test block
// widths, base table and shared types; no dependencies
`default_nettype none
package mrpt_pkg;
    localparam int WIDTH      = 64;
    localparam int BASE_COUNT = 11;
    localparam int BIT_W      = $clog2(WIDTH);
    localparam int BASE_IDX_W = $clog2(BASE_COUNT + 1);

    typedef logic [WIDTH-1:0] word_t;

    // command to the modular multiplier
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        word_t p;
    } mul_rsp_t;

    function automatic word_t base_of(input logic [BASE_IDX_W-1:0] idx);
        word_t r;
        case (idx)
            4'd0:    r = word_t'(2);
            4'd1:    r = word_t'(3);
            4'd2:    r = word_t'(5);
            4'd3:    r = word_t'(7);
            4'd4:    r = word_t'(11);
            4'd5:    r = word_t'(13);
            4'd6:    r = word_t'(17);
            4'd7:    r = word_t'(19);
            4'd8:    r = word_t'(23);
            4'd9:    r = word_t'(29);
            4'd10:   r = word_t'(31);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/miller_rabin_primality_test_top.sv -----
// top level of the deterministic miller-rabin primality test
// depends on mrpt_pkg, mrpt_modmul and the macros header
//
//  channel | direction | ports                       | payload
//  s_      | in        | s_valid, s_ready, s_number  | 64-bit value
//  m_      | out       | m_valid, m_ready, m_is_prime| 1 bit
//
// one item at a time; the shared multiplier takes one modular multiply at a
// time, and the sequencer adds issue and handoff around each one; about 128
// multiplies per base and up to eleven bases; values of 2 or less and even
// values give their result the cycle after the item is taken
// synchronous active-low reset returns to idle and drops m_valid
// a stalled result holds in the output register; s_ready stays low until taken
`default_nettype none
`include "miller_rabin_primality_test_top_macros.svh"
module miller_rabin_primality_test_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_number,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_prime
);
    typedef enum logic [3:0] {
        IDLE, SPLIT, BASE, POW_MUL, POW_SQR, POW_NEXT, SQ_MUL, SQ_CHECK, DONE
    } state_t;

    state_t state_reg;
    mrpt_pkg::word_t n_reg, d_reg, e_reg, c_reg, bb_reg;
    logic [mrpt_pkg::BIT_W-1:0] s_reg, j_reg;
    logic [mrpt_pkg::BASE_IDX_W-1:0] idx_reg;
    logic prime_reg, wait_reg;
    mrpt_pkg::mul_req_t req;
    mrpt_pkg::mul_rsp_t rsp;
    mrpt_pkg::word_t n_in, base_w, nm1;

    assign n_in   = s_number[mrpt_pkg::WIDTH-1:0];
    assign base_w = mrpt_pkg::base_of(idx_reg);
    assign nm1    = n_reg - mrpt_pkg::word_t'(1);

    mrpt_modmul u_mul (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            m_valid   <= 1'b0;
            req.start <= 1'b0;
            wait_reg  <= 1'b0;
        end else begin
            req.start <= 1'b0;
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        n_reg <= n_in;
                        if (n_in <= mrpt_pkg::word_t'(2) || !n_in[0]) begin
                            prime_reg <= (n_in == mrpt_pkg::word_t'(2));
                            state_reg <= DONE;
                            m_valid   <= 1'b1;
                        end else begin
                            d_reg     <= n_in - mrpt_pkg::word_t'(1);
                            s_reg     <= '0;
                            state_reg <= SPLIT;
                        end
                    end
                end
                // strip trailing zeros, one per cycle
                SPLIT: begin
                    if (!d_reg[0]) begin
                        d_reg <= d_reg >> 1;
                        s_reg <= s_reg + mrpt_pkg::BIT_W'(1);
                    end else begin
                        idx_reg   <= '0;
                        state_reg <= BASE;
                    end
                end
                BASE: begin
                    if (idx_reg == mrpt_pkg::BASE_IDX_W'(mrpt_pkg::BASE_COUNT)
                            || base_w >= n_reg) begin
                        prime_reg <= 1'b1;
                        state_reg <= DONE;
                        m_valid   <= 1'b1;
                    end else begin
                        c_reg     <= mrpt_pkg::word_t'(1);
                        bb_reg    <= base_w;
                        e_reg     <= d_reg;
                        state_reg <= POW_MUL;
                    end
                end
                // right-to-left square and multiply
                POW_MUL: begin
                    if (!wait_reg) begin
                        if (e_reg == '0) begin
                            j_reg     <= '0;
                            state_reg <= SQ_CHECK;
                        end else if (e_reg[0]) begin
                            req.start <= 1'b1;
                            req.a <= c_reg; req.b <= bb_reg; req.m <= n_reg;
                            wait_reg  <= 1'b1;
                        end else begin
                            state_reg <= POW_SQR;
                        end
                    end else if (rsp.done) begin
                        c_reg     <= rsp.p;
                        wait_reg  <= 1'b0;
                        state_reg <= POW_SQR;
                    end
                end
                POW_SQR: begin
                    if (!wait_reg) begin
                        req.start <= 1'b1;
                        req.a <= bb_reg; req.b <= bb_reg; req.m <= n_reg;
                        wait_reg  <= 1'b1;
                    end else if (rsp.done) begin
                        bb_reg    <= rsp.p;
                        wait_reg  <= 1'b0;
                        state_reg <= POW_NEXT;
                    end
                end
                POW_NEXT: begin
                    e_reg     <= e_reg >> 1;
                    state_reg <= POW_MUL;
                end
                SQ_CHECK: begin
                    if (j_reg == s_reg) begin
                        if (c_reg != mrpt_pkg::word_t'(1)) begin
                            prime_reg <= 1'b0;
                            state_reg <= DONE;
                            m_valid   <= 1'b1;
                        end else begin
                            idx_reg   <= idx_reg + mrpt_pkg::BASE_IDX_W'(1);
                            state_reg <= BASE;
                        end
                    end else begin
                        req.start <= 1'b1;
                        req.a <= c_reg; req.b <= c_reg; req.m <= n_reg;
                        state_reg <= SQ_MUL;
                    end
                end
                SQ_MUL: begin
                    if (rsp.done) begin
                        if (rsp.p == mrpt_pkg::word_t'(1) && c_reg != mrpt_pkg::word_t'(1)
                                && c_reg != nm1) begin
                            prime_reg <= 1'b0;
                            state_reg <= DONE;
                            m_valid   <= 1'b1;
                        end else begin
                            c_reg     <= rsp.p;
                            j_reg     <= j_reg + mrpt_pkg::BIT_W'(1);
                            state_reg <= SQ_CHECK;
                        end
                    end
                end
                DONE: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == IDLE);
    assign m_is_prime = prime_reg;

    `MRPT_ASSERT(a_no_accept_busy, m_valid |-> !s_ready, "input taken while result pending")
    `MRPT_ASSERT(a_hold_result, m_valid && !m_ready |=> m_valid && $stable(m_is_prime), "unstable")
    `MRPT_ASSERT(a_even_done, s_valid && s_ready && !s_number[0] |=> m_valid, "even value not settled")
    `MRPT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "reset did not clear result")
endmodule
`default_nettype wire

// ----- hdl/mrpt_modmul.sv -----
// shift-and-add modular multiplier, one bit of b per cycle
// depends on mrpt_pkg
`default_nettype none
module mrpt_modmul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mrpt_pkg::mul_req_t req,
    output mrpt_pkg::mul_rsp_t     rsp
);
    mrpt_pkg::word_t acc_reg, a_reg, b_reg, m_reg;
    logic [mrpt_pkg::BIT_W-1:0] bit_reg;
    logic busy_reg, done_reg;
    mrpt_pkg::word_t dbl, sum;
    logic [mrpt_pkg::WIDTH:0] t1, t2;

    // acc = 2*acc mod m, then + a mod m when the top bit of b is set; values stay below m
    always_comb begin
        t1  = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl = (t1 >= {1'b0, m_reg}) ? mrpt_pkg::word_t'(t1 - {1'b0, m_reg})
                                    : t1[mrpt_pkg::WIDTH-1:0];
        t2  = {1'b0, dbl} + {1'b0, a_reg};
        if (b_reg[mrpt_pkg::WIDTH-1]) begin
            sum = (t2 >= {1'b0, m_reg}) ? mrpt_pkg::word_t'(t2 - {1'b0, m_reg})
                                        : t2[mrpt_pkg::WIDTH-1:0];
        end else begin
            sum = dbl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                acc_reg  <= '0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                m_reg    <= req.m;
                bit_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg <= sum;
                b_reg   <= b_reg << 1;
                bit_reg <= bit_reg + mrpt_pkg::BIT_W'(1);
                if (bit_reg == mrpt_pkg::BIT_W'(mrpt_pkg::WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;
endmodule
`default_nettype wire

// ----- tb/sv/tb_miller_rabin_primality_test_top.sv -----
// testbench for the miller-rabin primality test block
// depends on mrpt_pkg and miller_rabin_primality_test_top; self-checking
`timescale 1ns / 100ps
`default_nettype none
module tb_miller_rabin_primality_test_top;
    // the stall limit must cover a large prime, which sees no handshake while it runs
    localparam int STALL_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 30000;
    localparam int DRAIN_CYCLES = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_number = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_is_prime;

    // pending numbers and predicted verdicts
    logic [63:0] number_q[$];
    bit          verdict_q[$];
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_recv = 1'b0;
    bit          s_fire = 1'b0;
    int          quiet_cycles = 0;

    miller_rabin_primality_test_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_number(s_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_prime(m_is_prime)
    );

    always #4 aclk = ~aclk;

    // (a + b) mod m with a, b < m, no overflow
    function automatic mrpt_pkg::word_t add_mod(mrpt_pkg::word_t a, mrpt_pkg::word_t b,
                                                mrpt_pkg::word_t m);
        mrpt_pkg::word_t gap;
        gap = m - b;
        return (a >= gap) ? a - gap : a + b;
    endfunction

    function automatic mrpt_pkg::word_t mul_mod(mrpt_pkg::word_t a, mrpt_pkg::word_t b,
                                                mrpt_pkg::word_t m);
        mrpt_pkg::word_t acc;
        acc = '0;
        for (int k = mrpt_pkg::WIDTH - 1; k >= 0; k--) begin
            acc = add_mod(acc, acc, m);
            if (b[k]) acc = add_mod(acc, a, m);
        end
        return acc;
    endfunction

    function automatic mrpt_pkg::word_t pow_mod(mrpt_pkg::word_t b, mrpt_pkg::word_t e,
                                                mrpt_pkg::word_t m);
        mrpt_pkg::word_t acc;
        acc = 1;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // deterministic verdict over the fixed prime bases below 32
    function automatic bit prime_verdict(logic [63:0] raw);
        mrpt_pkg::word_t n, d, c, sq;
        int    s;
        int    witness[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        n = raw[mrpt_pkg::WIDTH-1:0];
        if (n <= 2 || !n[0]) return n == 2;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < 11; i++) begin
            if (mrpt_pkg::word_t'(witness[i]) >= n) break;
            c = pow_mod(mrpt_pkg::word_t'(witness[i]), d, n);
            for (int j = 0; j < s; j++) begin
                sq = mul_mod(c, c, n);
                if (sq == 1 && c != 1 && c != n - 1) return 1'b0;
                c = sq;
            end
            if (c != 1) return 1'b0;
        end
        return 1'b1;
    endfunction

    // driver: offers queued numbers at the falling edge, holds until taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                // item went in at the last rising edge
                if (number_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_number <= number_q.pop_front();
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid && number_q.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                s_number <= number_q.pop_front();
                s_valid  <= 1'b1;
            end
            m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predict at acceptance so ordering matches the block
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            verdict_q = {verdict_q, prime_verdict(s_number)};
    end

    // monitor: compares each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result is_prime=%0b", m_is_prime);
                err_count++;
            end else begin
                if (m_is_prime !== verdict_q[0]) begin
                    $error("is_prime mismatch: expected %0b actual %0b",
                           verdict_q[0], m_is_prime);
                    err_count++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    // watchdog: counts cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // random values, mostly odd, biased toward small ones so large primes stay few
    function automatic logic [63:0] rand_number();
        logic [63:0] v;
        int          pick;
        v = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick < 5) v = v & 64'hFFFF;
        else if (pick < 7) v = v & 64'hFFFF_FFFF;
        if ($urandom_range(3) != 0) v[0] = 1'b1;
        return v;
    endfunction

    task automatic wait_drained();
        while (number_q.size() > 0 || s_valid || verdict_q.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: edges, small primes, carmichael and strong pseudoprimes
        number_q = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd31, 64'd37,
                     64'd561, 64'd2047, 64'd3215031751, 64'd4294967291,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
                     64'h8000_0000_0000_0000, 64'd3825123056546413051,
                     64'd1000000007, 64'd25326001};
        send_idle_pct = 21;
        recv_idle_pct = 85;
        wait_drained();

        // receiver holds off long enough for a result to wait in the block
        hold_recv = 1'b1;
        for (int i = 0; i < 6; i++)
            number_q = {number_q, 64'd3 + 2 * $urandom_range(50)};
        send_idle_pct = 0;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_recv = 1'b0;
        wait_drained();

        send_idle_pct = 85;
        recv_idle_pct = 21;
        for (int i = 0; i < 40; i++) number_q = {number_q, rand_number()};
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 40; i++) number_q = {number_q, rand_number()};
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
